>>> rtl/tdtd_pkg.sv
`timescale 1ns / 1ps

package tdtd_pkg;

  // sizing
  localparam int INSN_QUEUE_DEPTH = 64;
  localparam int TOKEN_COUNT_MAX  = 64;
  localparam int TAG_W            = 16;
  localparam int CORE_COUNT       = 3;

  localparam int QA_W  = $clog2(INSN_QUEUE_DEPTH);
  localparam int CNT_W = $clog2(INSN_QUEUE_DEPTH + 1);
  localparam int TOK_W = $clog2(TOKEN_COUNT_MAX + 1);

  // command kinds
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // opcodes
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_STORE  = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd3;

  // memory types
  localparam logic [2:0] MT_WEIGHT = 3'd1;
  localparam logic [2:0] MT_INPUT  = 3'd2;

  // cores
  localparam logic [1:0] CORE_LOAD    = 2'd0;
  localparam logic [1:0] CORE_COMPUTE = 2'd1;
  localparam logic [1:0] CORE_STORE   = 2'd2;

  // one queue entry
  typedef struct packed {
    logic             fin;
    logic             s_next;
    logic             s_prev;
    logic             w_next;
    logic             w_prev;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // apply the request and load the result register
  } ctrl_cmd_t;

endpackage

>>> rtl/tdtd_ram.sv
`timescale 1ns / 1ps

module tdtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tdtd_ctrl.sv
`timescale 1ns / 1ps

module tdtd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output tdtd_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  assign in_tready   = rst_n && (state_r == ST_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.exec    = (state_r == ST_EXEC) && (!out_tvalid_r || out_tready);
  assign out_tvalid  = out_tvalid_r;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (cmd.exec) begin
          state_nxt      = ST_IDLE;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  a_capture_reads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == ST_RD)
    else $error("capture not followed by head read");

  a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> ($past(state_r) == ST_RD || $past(state_r) == ST_EXEC))
    else $error("execute without a head read");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_tvalid_r && state_r == ST_IDLE)
    else $error("execute did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !cmd.exec)
    else $error("pending result overwritten");

endmodule

>>> rtl/tdtd_dpath.sv
`timescale 1ns / 1ps

module tdtd_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tdtd_pkg::ctrl_cmd_t           cmd,
  input  logic                          in_cmd,
  input  logic [15:0]                   in_tag,
  input  logic [2:0]                    in_opcode,
  input  logic [2:0]                    in_mtype,
  input  logic                          in_wp,
  input  logic                          in_wn,
  input  logic                          in_sp,
  input  logic                          in_sn,
  output logic                          res_accepted,
  output logic                          res_issued,
  output logic [15:0]                   res_tag,
  output logic [1:0]                    res_core,
  output logic                          res_done,
  output logic                          res_overflow
);

  localparam int SUM_W = tdtd_pkg::QA_W + 1;
  localparam int NC    = tdtd_pkg::CORE_COUNT;

  // latched request
  logic        cmd_r;
  logic [15:0] tag_r;
  logic [2:0]  op_r, mt_r;
  logic        wp_r, wn_r, sp_r, sn_r;

  // queue bookkeeping and tokens
  logic [tdtd_pkg::QA_W-1:0]  head_r [NC];
  logic [tdtd_pkg::QA_W-1:0]  head_nxt [NC];
  logic [tdtd_pkg::CNT_W-1:0] cnt_r [NC];
  logic [tdtd_pkg::CNT_W-1:0] cnt_nxt [NC];
  logic [tdtd_pkg::TOK_W-1:0] tok_lc_r, tok_cl_r, tok_cs_r, tok_sc_r;
  logic [tdtd_pkg::TOK_W-1:0] tok_lc_nxt, tok_cl_nxt, tok_cs_nxt, tok_sc_nxt;
  logic [1:0]                 rot_r, rot_nxt;
  logic                       done_r, done_nxt;

  // result register
  logic        acc_r, iss_r, ovf_r;
  logic [15:0] itag_r;
  logic [1:0]  icore_r;
  logic        acc_nxt, iss_nxt, ovf_nxt;
  logic [15:0] itag_nxt;
  logic [1:0]  icore_nxt;

  // memories
  logic [tdtd_pkg::ENTRY_W-1:0] rd_data [NC];
  logic [NC-1:0]                we;
  logic [tdtd_pkg::QA_W-1:0]    waddr;
  tdtd_pkg::entry_t             wentry;
  tdtd_pkg::entry_t             ent [NC];

  logic [1:0]       push_core;
  logic [SUM_W-1:0] tail_sum;
  logic [NC-1:0]    rdy;
  logic             found;
  logic [1:0]       sel;
  tdtd_pkg::entry_t sel_e;

  function automatic logic [tdtd_pkg::QA_W-1:0] next_ptr(input logic [tdtd_pkg::QA_W-1:0] p);
    if (p == tdtd_pkg::QA_W'(tdtd_pkg::INSN_QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic sat_full(input logic [tdtd_pkg::TOK_W-1:0] t);
    return t >= tdtd_pkg::TOK_W'(tdtd_pkg::TOKEN_COUNT_MAX);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      tag_r <= in_tag;
      op_r  <= in_opcode;
      mt_r  <= in_mtype;
      wp_r  <= in_wp;
      wn_r  <= in_wn;
      sp_r  <= in_sp;
      sn_r  <= in_sn;
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_q
    tdtd_ram #(
      .WIDTH (tdtd_pkg::ENTRY_W),
      .DEPTH (tdtd_pkg::INSN_QUEUE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we[k]),
      .waddr (waddr),
      .wdata (wentry),
      .raddr (head_r[k]),
      .rdata (rd_data[k])
    );
    assign ent[k] = tdtd_pkg::entry_t'(rd_data[k]);
  end

  // sort a push onto its core
  always_comb begin
    if (op_r == tdtd_pkg::OP_LOAD &&
        (mt_r == tdtd_pkg::MT_WEIGHT || mt_r == tdtd_pkg::MT_INPUT)) begin
      push_core = tdtd_pkg::CORE_LOAD;
    end else if (op_r == tdtd_pkg::OP_STORE) begin
      push_core = tdtd_pkg::CORE_STORE;
    end else begin
      push_core = tdtd_pkg::CORE_COMPUTE;
    end
  end

  always_comb begin
    case (push_core)
      tdtd_pkg::CORE_LOAD:  tail_sum = SUM_W'(head_r[0]) + SUM_W'(cnt_r[0]);
      tdtd_pkg::CORE_STORE: tail_sum = SUM_W'(head_r[2]) + SUM_W'(cnt_r[2]);
      default:              tail_sum = SUM_W'(head_r[1]) + SUM_W'(cnt_r[1]);
    endcase
    if (tail_sum >= SUM_W'(tdtd_pkg::INSN_QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(tdtd_pkg::INSN_QUEUE_DEPTH);
    end
  end

  assign waddr = tail_sum[tdtd_pkg::QA_W-1:0];
  assign wentry = '{fin: (op_r == tdtd_pkg::OP_FINISH), s_next: sn_r, s_prev: sp_r,
                    w_next: wn_r, w_prev: wp_r, tag: tag_r[tdtd_pkg::TAG_W-1:0]};

  // head readiness: tokens toward a missing neighbour are ignored
  assign rdy[0] = (cnt_r[0] != '0) && !(ent[0].w_next && tok_cl_r == '0);
  assign rdy[1] = (cnt_r[1] != '0) && !(ent[1].w_prev && tok_lc_r == '0)
                                   && !(ent[1].w_next && tok_sc_r == '0);
  assign rdy[2] = (cnt_r[2] != '0) && !(ent[2].w_prev && tok_cs_r == '0);

  // first ready core in rotating order
  always_comb begin
    found = 1'b1;
    sel   = tdtd_pkg::CORE_LOAD;
    case (rot_r)
      tdtd_pkg::CORE_COMPUTE: begin
        if (rdy[1]) sel = tdtd_pkg::CORE_COMPUTE;
        else if (rdy[2]) sel = tdtd_pkg::CORE_STORE;
        else if (rdy[0]) sel = tdtd_pkg::CORE_LOAD;
        else found = 1'b0;
      end
      tdtd_pkg::CORE_STORE: begin
        if (rdy[2]) sel = tdtd_pkg::CORE_STORE;
        else if (rdy[0]) sel = tdtd_pkg::CORE_LOAD;
        else if (rdy[1]) sel = tdtd_pkg::CORE_COMPUTE;
        else found = 1'b0;
      end
      default: begin
        if (rdy[0]) sel = tdtd_pkg::CORE_LOAD;
        else if (rdy[1]) sel = tdtd_pkg::CORE_COMPUTE;
        else if (rdy[2]) sel = tdtd_pkg::CORE_STORE;
        else found = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (sel)
      tdtd_pkg::CORE_COMPUTE: sel_e = ent[1];
      tdtd_pkg::CORE_STORE:   sel_e = ent[2];
      default:                sel_e = ent[0];
    endcase
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      head_nxt[k] = head_r[k];
      cnt_nxt[k]  = cnt_r[k];
    end
    tok_lc_nxt = tok_lc_r;
    tok_cl_nxt = tok_cl_r;
    tok_cs_nxt = tok_cs_r;
    tok_sc_nxt = tok_sc_r;
    rot_nxt    = rot_r;
    done_nxt   = done_r;
    we         = '0;
    acc_nxt    = 1'b0;
    iss_nxt    = 1'b0;
    ovf_nxt    = 1'b0;
    itag_nxt   = '0;
    icore_nxt  = '0;
    if (cmd.exec) begin
      if (cmd_r == tdtd_pkg::CMD_PUSH) begin
        for (int k = 0; k < NC; k++) begin
          if (push_core == 2'(k)) begin
            if (cnt_r[k] == tdtd_pkg::CNT_W'(tdtd_pkg::INSN_QUEUE_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              cnt_nxt[k] = cnt_r[k] + 1'b1;
              we[k]      = 1'b1;
              acc_nxt    = 1'b1;
            end
          end
        end
      end else if (found) begin
        for (int k = 0; k < NC; k++) begin
          if (sel == 2'(k)) begin
            head_nxt[k] = next_ptr(head_r[k]);
            cnt_nxt[k]  = cnt_r[k] - 1'b1;
          end
        end
        case (sel)
          tdtd_pkg::CORE_LOAD: begin
            if (sel_e.w_next) tok_cl_nxt = tok_cl_r - 1'b1;
            if (sel_e.s_next) begin
              if (sat_full(tok_lc_r)) ovf_nxt = 1'b1;
              else tok_lc_nxt = tok_lc_r + 1'b1;
            end
            rot_nxt = tdtd_pkg::CORE_COMPUTE;
          end
          tdtd_pkg::CORE_COMPUTE: begin
            if (sel_e.w_prev) tok_lc_nxt = tok_lc_r - 1'b1;
            if (sel_e.w_next) tok_sc_nxt = tok_sc_r - 1'b1;
            if (sel_e.s_prev) begin
              if (sat_full(tok_cl_r)) ovf_nxt = 1'b1;
              else tok_cl_nxt = tok_cl_r + 1'b1;
            end
            if (sel_e.s_next) begin
              if (sat_full(tok_cs_r)) ovf_nxt = 1'b1;
              else tok_cs_nxt = tok_cs_r + 1'b1;
            end
            rot_nxt = tdtd_pkg::CORE_STORE;
          end
          default: begin
            if (sel_e.w_prev) tok_cs_nxt = tok_cs_r - 1'b1;
            if (sel_e.s_prev) begin
              if (sat_full(tok_sc_r)) ovf_nxt = 1'b1;
              else tok_sc_nxt = tok_sc_r + 1'b1;
            end
            rot_nxt = tdtd_pkg::CORE_LOAD;
          end
        endcase
        done_nxt  = sel_e.fin;
        iss_nxt   = 1'b1;
        itag_nxt  = 16'(sel_e.tag);
        icore_nxt = sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NC; k++) begin
        head_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
      tok_lc_r <= '0;
      tok_cl_r <= '0;
      tok_cs_r <= '0;
      tok_sc_r <= '0;
      rot_r    <= tdtd_pkg::CORE_LOAD;
      done_r   <= 1'b0;
    end else begin
      for (int k = 0; k < NC; k++) begin
        head_r[k] <= head_nxt[k];
        cnt_r[k]  <= cnt_nxt[k];
      end
      tok_lc_r <= tok_lc_nxt;
      tok_cl_r <= tok_cl_nxt;
      tok_cs_r <= tok_cs_nxt;
      tok_sc_r <= tok_sc_nxt;
      rot_r    <= rot_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r   <= acc_nxt;
      iss_r   <= iss_nxt;
      ovf_r   <= ovf_nxt;
      itag_r  <= itag_nxt;
      icore_r <= icore_nxt;
    end
  end

  assign res_accepted = acc_r;
  assign res_issued   = iss_r;
  assign res_tag      = itag_r;
  assign res_core     = icore_r;
  assign res_done     = done_r;
  assign res_overflow = ovf_r;

endmodule

>>> rtl/task_dependency_token_dispatcher.sv
`timescale 1ns / 1ps

// Dependency-token dispatcher for a load / compute / store core trio.
// Input channel (in_*): one request per handshake. in_tuser selects push
// (sort the instruction into its core queue) or step (issue the first
// ready queue head in rotating order, consume its wait tokens, add its
// signal tokens to the four saturating counters between neighbours).
// Output channel (out_*): exactly one result per request, in order.
// Steps per request: latch, queue head read (the registered read port
// of each queue memory), evaluate and update; a new request is accepted
// only after the previous one has been evaluated and applied.
// A finished result sits in the output register; the next request is
// accepted meanwhile, and its evaluation holds until the receiver has
// taken the earlier result, so a stalled receiver stalls the input after
// one request in flight.
// Reset (rst_n low, synchronous): queues empty, all token counters zero,
// rotation starts at the load core, done flag clear, no result pending;
// in_tready stays low while rst_n is low.
module task_dependency_token_dispatcher (
  input  logic        clk,
  input  logic        rst_n,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // insn_tag[15:0], opcode[18:16], mem_space[21:19],
                                  // wait_prev[22], wait_next[23], signal_prev[24],
                                  // signal_next[25], zero[31:26]
  input  logic        in_tuser,   // cmd: 0 push, 1 step
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // issued_tag[15:0], issued_core[17:16], done_res[18],
                                  // overflow[19], zero[23:20]
  output logic [1:0]  out_tuser   // accepted[0], issued[1]
);

  tdtd_pkg::ctrl_cmd_t cmd;

  logic        res_accepted, res_issued, res_done, res_overflow;
  logic [15:0] res_tag;
  logic [1:0]  res_core;

  // sequencing and handshakes
  tdtd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // queues, token counters, issue choice and result register
  tdtd_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_cmd       (in_tuser),
    .in_tag       (in_tdata[15:0]),
    .in_opcode    (in_tdata[18:16]),
    .in_mtype     (in_tdata[21:19]),
    .in_wp        (in_tdata[22]),
    .in_wn        (in_tdata[23]),
    .in_sp        (in_tdata[24]),
    .in_sn        (in_tdata[25]),
    .res_accepted (res_accepted),
    .res_issued   (res_issued),
    .res_tag      (res_tag),
    .res_core     (res_core),
    .res_done     (res_done),
    .res_overflow (res_overflow)
  );

  // pack the result register onto the bus
  assign out_tdata = {4'b0, res_overflow, res_done, res_core, res_tag};
  assign out_tuser = {res_issued, res_accepted};

endmodule
